// File: sv/hkt_pkg.sv
package hkt_pkg;

    localparam int MAX_KNOTS = 256;
    localparam int LANES     = 4;
    localparam int FRAC_BITS = 16;
    localparam int AW        = 8;

    // ceil(2^33 / 3): (x * DIV3_RECIP) >> 33 is floor(x / 3) for any 32-bit x
    localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_LOCATE  = 2'd1;
    localparam logic [1:0] FUNC_SEGMENT = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_BADIX = 2'd2;

    typedef logic signed [31:0] t_word;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOC,
        S_HINT1,
        S_HINT2,
        S_BIS,
        S_BCMP,
        S_LDONE,
        S_INS0,
        S_INSN,
        S_SHIFT,
        S_SHWR,
        S_SEGL,
        S_SEGR,
        S_DIV,
        S_SIGN,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic          we;
        logic          use_in;
        logic [AW-1:0] raddr;
        logic [AW-1:0] waddr;
        logic          cap_l;
        logic          cap_r;
        logic          mul;
    } t_lane_ctl;

    typedef struct packed {
        t_word coef_0;
        t_word coef_1;
        t_word coef_2;
        t_word coef_3;
    } t_lane_res;

endpackage

// File: sv/hkt_lane.sv
module hkt_lane (
    input  logic              i_clk,
    input  hkt_pkg::t_lane_ctl i_ctl,
    input  hkt_pkg::t_word    i_value,
    input  hkt_pkg::t_word    i_tangent,
    input  hkt_pkg::t_word    i_scale,
    output hkt_pkg::t_lane_res o_res
);
    import hkt_pkg::*;

    t_word vmem [MAX_KNOTS];
    t_word tmem [MAX_KNOTS];
    t_word r_vrd, r_trd;
    t_word r_v0, r_t0, r_v3, r_t3;
    logic signed [63:0] r_p0, r_p3;
    logic signed [63:0] rb0, rb3;
    logic signed [47:0] rnd0, rnd3;
    logic signed [48:0] sum1, sum2;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            vmem[i_ctl.waddr] <= i_ctl.use_in ? i_value : r_vrd;
            tmem[i_ctl.waddr] <= i_ctl.use_in ? i_tangent : r_trd;
        end
        r_vrd <= vmem[i_ctl.raddr];
        r_trd <= tmem[i_ctl.raddr];
        if (i_ctl.cap_l) begin
            r_v0 <= r_vrd;
            r_t0 <= r_trd;
        end
        if (i_ctl.cap_r) begin
            r_v3 <= r_vrd;
            r_t3 <= r_trd;
        end
        if (i_ctl.mul) begin
            r_p0 <= r_t0 * i_scale;
            r_p3 <= r_t3 * i_scale;
        end
    end

    // round to nearest, ties up, then saturate
    always_comb begin
        rb0  = r_p0 + (64'sd1 <<< (FRAC_BITS - 1));
        rb3  = r_p3 + (64'sd1 <<< (FRAC_BITS - 1));
        rnd0 = 48'(rb0 >>> FRAC_BITS);
        rnd3 = 48'(rb3 >>> FRAC_BITS);
        sum1 = 49'(r_v0) + 49'(rnd0);
        sum2 = 49'(r_v3) - 49'(rnd3);
        o_res.coef_0 = r_v0;
        o_res.coef_3 = r_v3;
        if (sum1 > 49'sd2147483647)       o_res.coef_1 = 32'sh7FFFFFFF;
        else if (sum1 < -49'sd2147483648) o_res.coef_1 = 32'sh80000000;
        else                              o_res.coef_1 = sum1[31:0];
        if (sum2 > 49'sd2147483647)       o_res.coef_2 = 32'sh7FFFFFFF;
        else if (sum2 < -49'sd2147483648) o_res.coef_2 = 32'sh80000000;
        else                              o_res.coef_2 = sum2[31:0];
    end

endmodule

// File: sv/hermite_knot_table_core.sv
// Sorted knot table with four lanes of value/tangent per knot.
// Input: pulse i_start with the item fields while o_busy is low; the item
// is taken at that edge and o_busy is high from the next cycle until the work
// is done. Results appear one per cycle, each for a single cycle under
// o_valid; o_last marks the final beat of an item. There is no stall.
// Insert and locate give one beat; segment gives four beats (one per lane,
// consecutive cycles) or one status beat on a bad index.
// A full-table insert or a bad segment index gives its status beat straight
// from the idle state, and o_busy stays low. Locate stops on a hint hit,
// checked against the next knot unless the hint is the last knot, and
// otherwise bisects through the single knot memory read port. Insert locates
// first, then shifts each entry above its slot up by one and writes the new
// entry into the slot. Segment steps through two knot reads, a reciprocal
// multiply for the divide by three of the span, a sign fix and one multiply
// stage before its first beat.
// Reset clears the knot count and the search hint; the stores need no
// clearing since only entries below the count are ever read.
// A new item can be taken in the cycle its last result is shown.
module hermite_knot_table_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [1:0]            i_func,
    input  hkt_pkg::t_word        i_knot,
    input  hkt_pkg::t_word        i_value_0,
    input  hkt_pkg::t_word        i_value_1,
    input  hkt_pkg::t_word        i_value_2,
    input  hkt_pkg::t_word        i_value_3,
    input  hkt_pkg::t_word        i_tangent_0,
    input  hkt_pkg::t_word        i_tangent_1,
    input  hkt_pkg::t_word        i_tangent_2,
    input  hkt_pkg::t_word        i_tangent_3,
    input  logic [7:0]            i_left_index,
    input  logic [7:0]            i_right_index,
    output logic                  o_valid,
    output logic [7:0]            o_position,
    output hkt_pkg::t_word        o_start_param,
    output hkt_pkg::t_word        o_end_param,
    output logic [1:0]            o_lane,
    output hkt_pkg::t_word        o_coef_0,
    output hkt_pkg::t_word        o_coef_1,
    output hkt_pkg::t_word        o_coef_2,
    output hkt_pkg::t_word        o_coef_3,
    output logic                  o_last,
    output logic [1:0]            o_status
);
    import hkt_pkg::*;

    t_state r_state, n_state;
    logic [1:0]    r_func, n_func;
    t_word         r_k, n_k;
    t_word         r_val [LANES];
    t_word         r_tan [LANES];
    t_word         in_val [4];
    t_word         in_tan [4];
    logic [AW-1:0] r_li, n_li, r_ri, n_ri;
    logic [AW:0]   r_count, n_count;
    logic [AW-1:0] r_hint, n_hint;
    logic [AW-1:0] r_lo, n_lo, r_hi, n_hi, r_idx, n_idx, r_pos, n_pos;
    logic [AW:0]   r_slot, n_slot, r_i, n_i;
    t_word         r_sp, n_sp, r_ep, n_ep, r_scale, n_scale;
    logic [31:0]   r_dq, n_dq;
    logic          r_neg, n_neg;
    logic [1:0]    r_cnt, n_cnt;
    logic [AW:0]   lo_sum;
    logic [63:0]   dprod;
    logic [33:0]   diff;

    logic          r_valid, n_valid;
    logic [7:0]    r_opos, n_opos;
    t_word         r_osp, n_osp, r_oep, n_oep;
    logic [1:0]    r_olane, n_olane;
    t_lane_res     r_ores, n_ores;
    logic          r_olast, n_olast;
    logic [1:0]    r_ostat, n_ostat;

    t_word         kmem [MAX_KNOTS];
    t_word         r_krd;
    logic          kwe;
    logic [AW-1:0] kwaddr;
    t_word         kwdata;
    t_lane_ctl     ctl;
    t_lane_res     lres [LANES];

    assign in_val = '{i_value_0, i_value_1, i_value_2, i_value_3};
    assign in_tan = '{i_tangent_0, i_tangent_1, i_tangent_2, i_tangent_3};

    always_ff @(posedge i_clk) begin
        if (kwe) kmem[kwaddr] <= kwdata;
        r_krd <= kmem[ctl.raddr];
    end

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            hkt_lane u_lane (
                .i_clk    (i_clk),
                .i_ctl    (ctl),
                .i_value  (r_val[g]),
                .i_tangent(r_tan[g]),
                .i_scale  (r_scale),
                .o_res    (lres[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_hint  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hint  <= n_hint;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            for (int l = 0; l < LANES; l++) begin
                r_val[l] <= in_val[l];
                r_tan[l] <= in_tan[l];
            end
        end
        r_func <= n_func;   r_k <= n_k;       r_li <= n_li;     r_ri <= n_ri;
        r_lo <= n_lo;       r_hi <= n_hi;     r_idx <= n_idx;   r_pos <= n_pos;
        r_slot <= n_slot;   r_i <= n_i;       r_sp <= n_sp;     r_ep <= n_ep;
        r_scale <= n_scale; r_dq <= n_dq;
        r_neg <= n_neg;     r_cnt <= n_cnt;
        r_opos <= n_opos;   r_osp <= n_osp;   r_oep <= n_oep;   r_olane <= n_olane;
        r_ores <= n_ores;   r_olast <= n_olast; r_ostat <= n_ostat;
    end

    always_comb begin
        n_state = r_state; n_func = r_func; n_k = r_k; n_li = r_li; n_ri = r_ri;
        n_count = r_count; n_hint = r_hint; n_lo = r_lo; n_hi = r_hi;
        n_idx = r_idx; n_pos = r_pos; n_slot = r_slot; n_i = r_i;
        n_sp = r_sp; n_ep = r_ep; n_scale = r_scale; n_dq = r_dq;
        n_neg = r_neg; n_cnt = r_cnt;
        n_valid = 1'b0; n_opos = '0; n_osp = '0; n_oep = '0; n_olane = '0;
        n_ores = '0; n_olast = 1'b1; n_ostat = STAT_OK;
        kwe = 1'b0; kwaddr = '0; kwdata = r_k;
        ctl = '0;
        lo_sum = {1'b0, r_lo} + {1'b0, r_hi};
        dprod = 64'(r_dq) * 64'(DIV3_RECIP);
        diff = 34'(r_ep) - 34'(r_sp);

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func = i_func;
                    n_k    = i_knot;
                    n_li   = i_left_index;
                    n_ri   = i_right_index;
                    case (i_func)
                        FUNC_INSERT: begin
                            if (r_count >= (AW+1)'(MAX_KNOTS)) begin
                                n_valid = 1'b1;
                                n_ostat = STAT_FULL;
                            end else begin
                                n_state = S_LOC;
                            end
                        end
                        FUNC_LOCATE: n_state = S_LOC;
                        FUNC_SEGMENT: begin
                            if ({1'b0, i_left_index} >= r_count ||
                                {1'b0, i_right_index} >= r_count) begin
                                n_valid = 1'b1;
                                n_ostat = STAT_BADIX;
                            end else begin
                                ctl.raddr = i_left_index;
                                n_state   = S_SEGL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LOC: begin
                n_lo  = '0;
                n_hi  = AW'(r_count - 1'b1);
                n_idx = '0;
                if (r_count == '0) begin
                    n_hint  = '0;
                    n_pos   = '0;
                    n_state = S_LDONE;
                end else if ({1'b0, r_hint} < r_count) begin
                    ctl.raddr = r_hint;
                    n_state   = S_HINT1;
                end else begin
                    n_state = S_BIS;
                end
            end
            S_HINT1: begin
                if ({1'b0, r_hint} == r_count - 1'b1) begin
                    if (r_k >= r_krd) begin
                        n_pos   = r_hint;
                        n_state = S_LDONE;
                    end else begin
                        n_state = S_BIS;
                    end
                end else if (r_k >= r_krd) begin
                    ctl.raddr = r_hint + 1'b1;
                    n_state   = S_HINT2;
                end else begin
                    n_state = S_BIS;
                end
            end
            S_HINT2: begin
                if (r_k < r_krd) begin
                    n_pos   = r_hint;
                    n_state = S_LDONE;
                end else begin
                    n_state = S_BIS;
                end
            end
            S_BIS: begin
                if ({1'b0, r_hi} > {1'b0, r_lo} + 1'b1) begin
                    ctl.raddr = r_idx;
                    n_state   = S_BCMP;
                end else begin
                    n_hint  = r_idx;
                    n_pos   = r_idx;
                    n_state = S_LDONE;
                end
            end
            S_BCMP: begin
                if (r_krd > r_k) begin
                    n_hi   = r_idx;
                    lo_sum = {1'b0, r_lo} + {1'b0, r_idx};
                end else begin
                    n_lo   = r_idx;
                    lo_sum = {1'b0, r_idx} + {1'b0, r_hi};
                end
                n_idx   = lo_sum[AW:1];
                n_state = S_BIS;
            end
            S_LDONE: begin
                if (r_func == FUNC_LOCATE) begin
                    n_valid = 1'b1;
                    n_opos  = r_pos;
                    n_state = S_IDLE;
                end else if (r_count == '0) begin
                    n_slot  = '0;
                    n_i     = r_count;
                    n_state = S_SHIFT;
                end else begin
                    ctl.raddr = '0;
                    n_state   = S_INS0;
                end
            end
            S_INS0: begin
                if (r_k < r_krd) begin
                    n_slot  = '0;
                    n_i     = r_count;
                    n_state = S_SHIFT;
                end else begin
                    ctl.raddr = AW'(r_count - 1'b1);
                    n_state   = S_INSN;
                end
            end
            S_INSN: begin
                n_slot  = (r_k >= r_krd) ? r_count : {1'b0, r_pos} + 1'b1;
                n_i     = r_count;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_i > r_slot) begin
                    ctl.raddr = AW'(r_i - 1'b1);
                    n_state   = S_SHWR;
                end else begin
                    // drop the new entry into its slot
                    kwe        = 1'b1;
                    kwaddr     = r_slot[AW-1:0];
                    kwdata     = r_k;
                    ctl.we     = 1'b1;
                    ctl.use_in = 1'b1;
                    ctl.waddr  = r_slot[AW-1:0];
                    n_count    = r_count + 1'b1;
                    n_valid    = 1'b1;
                    n_opos     = r_pos;
                    n_state    = S_IDLE;
                end
            end
            S_SHWR: begin
                kwe       = 1'b1;
                kwaddr    = r_i[AW-1:0];
                kwdata    = r_krd;
                ctl.we    = 1'b1;
                ctl.waddr = r_i[AW-1:0];
                n_i       = r_i - 1'b1;
                n_state   = S_SHIFT;
            end
            S_SEGL: begin
                ctl.cap_l = 1'b1;
                ctl.raddr = r_ri;
                n_sp      = r_krd;
                n_state   = S_SEGR;
            end
            S_SEGR: begin
                ctl.cap_r = 1'b1;
                n_ep      = r_krd;
                n_state   = S_DIV;
                diff      = 34'(r_krd) - 34'(r_sp);
                n_neg     = diff[33];
                // the span magnitude always fits in 32 bits
                n_dq      = diff[33] ? 32'(-diff) : diff[31:0];
            end
            S_DIV: begin
                // divide the magnitude by three through the reciprocal
                n_dq    = {1'b0, dprod[63:33]};
                n_state = S_SIGN;
            end
            S_SIGN: begin
                n_scale = r_neg ? -r_dq : r_dq;
                n_state = S_MUL;
            end
            S_MUL: begin
                ctl.mul = 1'b1;
                n_cnt   = '0;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_valid = 1'b1;
                n_osp   = r_sp;
                n_oep   = r_ep;
                n_olane = r_cnt;
                n_ores  = lres[r_cnt];
                n_olast = (r_cnt == 2'(LANES - 1));
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == 2'(LANES - 1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state != S_IDLE && r_state != S_OUT && n_state == S_IDLE) begin
            n_olast = 1'b1;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_position    = r_opos;
    assign o_start_param = r_osp;
    assign o_end_param   = r_oep;
    assign o_lane        = r_olane;
    assign o_coef_0      = r_ores.coef_0;
    assign o_coef_1      = r_ores.coef_1;
    assign o_coef_2      = r_ores.coef_2;
    assign o_coef_3      = r_ores.coef_3;
    assign o_last        = r_olast;
    assign o_status      = r_ostat;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(MAX_KNOTS))
        else $error("knot count beyond table depth");

    a_lane_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid && o_lane == $past(o_lane) + 2'd1)
        else $error("segment beats not consecutive");

    a_bad_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STAT_OK |-> o_last && o_coef_1 == '0)
        else $error("status beat not final or not cleared");

    a_shift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHWR |-> r_i <= r_count && r_i != '0)
        else $error("shift writes outside table");

endmodule
